/* sv/vbra_pkg.sv */
package vbra_pkg;

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_COMMIT  = 2'd1,
        OP_PEEK    = 2'd2,
        OP_RELEASE = 2'd3
    } opcode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    localparam int unsigned SIZE_W = 16;
    localparam logic [SIZE_W-1:0] BUF_SIZE_RESET = 16'd4096;

endpackage

/* sv/vbra_size_queue.sv */
module vbra_size_queue #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned DW    = 16
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/variable_block_ring_allocator.sv */
// result: the beat is captured on accept (ST_IDLE to ST_EXEC); the result is registered in
// ST_EXEC once the output register is free or drained. No new beat is taken while in ST_EXEC;
// a finished result waiting in the output register does not block the next accept
// reset: asynchronous active-low; pointers, flags and counts clear, buffer_size returns to 4096,
// the size queue memory is not cleared (only entries written by a reserve are ever read)
module variable_block_ring_allocator #(
    parameter int unsigned MAX_BLOCKS  = 16,
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] req_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [15:0] offset,
    output logic [15:0] block_size
);

    localparam int unsigned SW    = vbra_pkg::SIZE_W;
    localparam int unsigned QW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned CW    = ((OFFSET_BITS > SW) ? OFFSET_BITS : SW) + 1;
    localparam logic [QW-1:0]    LAST_IDX = QW'(MAX_BLOCKS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_BLOCKS);

    vbra_pkg::state_t state_reg, state_next;

    logic [SW-1:0]          buffer_size_reg;
    logic [OFFSET_BITS-1:0] read_start_reg, read_start_next;
    logic [OFFSET_BITS-1:0] write_end_reg, write_end_next;
    logic [OFFSET_BITS-1:0] trash_mark_reg, trash_mark_next;
    logic                   write_open_reg, write_open_next;
    logic                   read_open_reg, read_open_next;
    logic [QW-1:0]          head_reg, head_next;
    logic [QW-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    vbra_pkg::opcode_t op_reg;
    logic [SW-1:0]     size_reg;

    logic          out_valid_reg, out_valid_next;
    logic          ok_reg, ok_next;
    logic [15:0]   offset_reg, offset_next;
    logic [15:0]   block_size_reg, block_size_next;

    logic          q_wr_en;
    logic [SW-1:0] q_rd_data;

    logic          accept;
    logic          exec_fire;
    logic [CW-1:0] bs_w, rs_w, we_w, tm_w, sz_w, hd_w;
    logic [CW-1:0] place_w;
    logic [CW-1:0] end_sum_w, start_sum_w;
    logic          ordered, fit_after, fit_before, fit_wrap;
    logic          res_ok, peek_ok, peek_wrap, rel_ok;

    vbra_size_queue #(
        .DEPTH (MAX_BLOCKS),
        .AW    (QW),
        .DW    (SW)
    ) u_size_queue (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (tail_reg),
        .wr_data (size_reg),
        .rd_addr (head_reg),
        .rd_data (q_rd_data)
    );

    assign in_ready   = (state_reg == vbra_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign exec_fire  = (state_reg == vbra_pkg::ST_EXEC) && (!out_valid_reg || out_ready);

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign offset     = offset_reg;
    assign block_size = block_size_reg;

    // widened copies so every compare and sum sees full magnitudes
    assign bs_w = CW'(buffer_size_reg);
    assign rs_w = CW'(read_start_reg);
    assign we_w = CW'(write_end_reg);
    assign tm_w = CW'(trash_mark_reg);
    assign sz_w = CW'(size_reg);
    assign hd_w = CW'(q_rd_data);

    assign ordered    = (rs_w <= we_w);
    assign fit_after  = ordered && (bs_w > we_w) && ((bs_w - we_w) > sz_w);
    assign fit_before = !ordered && ((rs_w - we_w) > sz_w);
    assign fit_wrap   = ordered && (rs_w > sz_w);
    assign res_ok     = !write_open_reg && (count_reg != FULL_CNT)
                        && (fit_after || fit_before || fit_wrap);
    assign place_w    = (fit_after || fit_before) ? we_w : '0;
    assign end_sum_w  = place_w + sz_w;
    assign start_sum_w = rs_w + hd_w;

    assign peek_ok    = !read_open_reg && (count_reg != '0);
    assign peek_wrap  = (rs_w == bs_w) || ((trash_mark_reg != '0) && (rs_w == tm_w));
    assign rel_ok     = read_open_reg && (count_reg != '0);

    always_comb
    begin
        state_next      = state_reg;
        read_start_next = read_start_reg;
        write_end_next  = write_end_reg;
        trash_mark_next = trash_mark_reg;
        write_open_next = write_open_reg;
        read_open_next  = read_open_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        q_wr_en         = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        ok_next         = ok_reg;
        offset_next     = offset_reg;
        block_size_next = block_size_reg;

        unique case (state_reg)
            vbra_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = vbra_pkg::ST_EXEC;
                end
            end
            vbra_pkg::ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next      = vbra_pkg::ST_IDLE;
                    out_valid_next  = 1'b1;
                    ok_next         = 1'b0;
                    offset_next     = '0;
                    block_size_next = '0;
                    unique case (op_reg)
                        vbra_pkg::OP_RESERVE:
                        begin
                            if (res_ok)
                            begin
                                if (!(fit_after || fit_before))
                                begin
                                    trash_mark_next = write_end_reg;
                                end
                                write_end_next  = end_sum_w[OFFSET_BITS-1:0];
                                write_open_next = 1'b1;
                                q_wr_en         = 1'b1;
                                tail_next       = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                                count_next      = count_reg + 1'b1;
                                ok_next         = 1'b1;
                                offset_next     = place_w[15:0];
                            end
                        end
                        vbra_pkg::OP_COMMIT:
                        begin
                            ok_next         = write_open_reg;
                            write_open_next = 1'b0;
                        end
                        vbra_pkg::OP_PEEK:
                        begin
                            if (peek_ok)
                            begin
                                read_open_next  = 1'b1;
                                ok_next         = 1'b1;
                                block_size_next = q_rd_data;
                                if (peek_wrap)
                                begin
                                    read_start_next = '0;
                                    trash_mark_next = '0;
                                    offset_next     = '0;
                                end
                                else
                                begin
                                    offset_next = rs_w[15:0];
                                end
                            end
                        end
                        vbra_pkg::OP_RELEASE:
                        begin
                            read_open_next = 1'b0;
                            if (rel_ok)
                            begin
                                read_start_next = start_sum_w[OFFSET_BITS-1:0];
                                head_next       = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                                count_next      = count_reg - 1'b1;
                                ok_next         = 1'b1;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = vbra_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= vbra_pkg::ST_IDLE;
            buffer_size_reg <= vbra_pkg::BUF_SIZE_RESET;
            read_start_reg  <= '0;
            write_end_reg   <= '0;
            trash_mark_reg  <= '0;
            write_open_reg  <= 1'b0;
            read_open_reg   <= 1'b0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_wr_en)
            begin
                buffer_size_reg <= cfg_wr_data;
            end
            read_start_reg  <= read_start_next;
            write_end_reg   <= write_end_next;
            trash_mark_reg  <= trash_mark_next;
            write_open_reg  <= write_open_next;
            read_open_reg   <= read_open_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // captured beat and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= vbra_pkg::opcode_t'(opcode);
            size_reg <= req_size;
        end
        ok_reg         <= ok_next;
        offset_reg     <= offset_next;
        block_size_reg <= block_size_next;
    end

endmodule

/* tb/tb_variable_block_ring_allocator.sv */
`timescale 1ns / 100ps

module tb_variable_block_ring_allocator;

    localparam int BLOCK_SLOTS  = 16;
    localparam int MAX_GAP      = 19;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 204;
    localparam int IDLE_LIMIT   = 2000;

    typedef struct packed {
        logic        ok;
        logic [15:0] offset;
        logic [15:0] block_size;
    } outcome_t;

    typedef struct {
        vbra_pkg::opcode_t op;
        logic [15:0]       size;
        bit                pinned;
        outcome_t          want;
    } step_t;

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [15:0]       cfg_wr_data = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    vbra_pkg::opcode_t opcode      = vbra_pkg::OP_RESERVE;
    logic [15:0]       req_size    = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic              ok;
    logic [15:0]       offset;
    logic [15:0]       block_size;

    // expectation typed into the directed table, travels with the beat
    bit          pin_en   = 1'b0;
    outcome_t    pin_want = '0;

    bit          quiet       = 1'b0;
    int          mismatches  = 0;
    int          idle_cycles = 0;
    outcome_t    pending_outcomes [$];

    // allocator state as the testbench sees it
    logic [15:0] ring_cap = vbra_pkg::BUF_SIZE_RESET;
    logic [15:0] rd_start = '0;
    logic [15:0] wr_end   = '0;
    logic [15:0] trash_at = '0;
    bit          wr_open  = 1'b0;
    bit          rd_open  = 1'b0;
    logic [15:0] blk_len [BLOCK_SLOTS];
    logic [3:0]  q_head   = '0;
    logic [3:0]  q_tail   = '0;
    logic [4:0]  q_count  = '0;

    step_t steps [24];

    variable_block_ring_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .req_size    (req_size),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .offset      (offset),
        .block_size  (block_size)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic outcome_t ring_outcome(input vbra_pkg::opcode_t op,
                                              input logic [15:0] sz);
        outcome_t r;
        bit       ordered;
        bit       placed;
        r       = '0;
        placed  = 1'b0;
        ordered = rd_start <= wr_end;
        case (op)
            vbra_pkg::OP_RESERVE:
            begin
                if (!wr_open && q_count < BLOCK_SLOTS)
                begin
                    if (ordered && ring_cap > wr_end && ring_cap - wr_end > sz)
                        placed = 1'b1;
                    else if (!ordered && rd_start - wr_end > sz)
                        placed = 1'b1;
                    else if (ordered && rd_start > sz)
                    begin
                        // no room at the top: restart at zero, remember where the data stops
                        trash_at = wr_end;
                        wr_end   = '0;
                        placed   = 1'b1;
                    end
                end
                if (placed)
                begin
                    r.ok            = 1'b1;
                    r.offset        = wr_end;
                    blk_len[q_tail] = sz;
                    q_tail          = q_tail + 4'd1;
                    q_count         = q_count + 5'd1;
                    wr_end          = wr_end + sz;
                    wr_open         = 1'b1;
                end
            end
            vbra_pkg::OP_COMMIT:
            begin
                r.ok    = wr_open;
                wr_open = 1'b0;
            end
            vbra_pkg::OP_PEEK:
            begin
                if (!rd_open && q_count != 0)
                begin
                    if (rd_start == ring_cap || (trash_at != 0 && rd_start == trash_at))
                    begin
                        rd_start = '0;
                        trash_at = '0;
                    end
                    rd_open      = 1'b1;
                    r.ok         = 1'b1;
                    r.offset     = rd_start;
                    r.block_size = blk_len[q_head];
                end
            end
            default:
            begin
                if (rd_open && q_count != 0)
                begin
                    rd_start = rd_start + blk_len[q_head];
                    q_head   = q_head + 4'd1;
                    q_count  = q_count - 5'd1;
                    r.ok     = 1'b1;
                end
                rd_open = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        $display("mismatch on %s at %0t ns: got %0h, want %0h", what, $realtime, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                want = ring_outcome(opcode, req_size);
                if (pin_en)
                    want = pin_want;
                pending_outcomes.insert(pending_outcomes.size(), want);
            end
            if (out_valid && out_ready)
            begin
                if (pending_outcomes.size() == 0)
                    flag_mismatch("result beat with nothing pending", offset, 16'd0);
                else
                begin
                    want = pending_outcomes[0];
                    pending_outcomes.delete(0);
                    if (ok !== want.ok)
                        flag_mismatch("ok", 16'(ok), 16'(want.ok));
                    if (offset !== want.offset)
                        flag_mismatch("offset", offset, want.offset);
                    if (block_size !== want.block_size)
                        flag_mismatch("block_size", block_size, want.block_size);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stall before each beat, none in quiet phases
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send(input vbra_pkg::opcode_t op, input logic [15:0] sz, input bit pinned,
                        input outcome_t want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        req_size <= sz;
        pin_en   <= pinned;
        pin_want <= want;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_outcomes.size() != 0);
    endtask

    task automatic write_cap(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ring_cap   = v;
    endtask

    function automatic logic [15:0] pick_size();
        int s;
        s = $urandom_range(0, 99);
        if (s < 70)
            return 16'($urandom_range(0, ring_cap / 32));
        else if (s < 92)
            return 16'($urandom_range(0, ring_cap));
        return 16'($urandom_range(0, 65535));
    endfunction

    // mostly well-formed reserve/commit and peek/release pairs, some noise
    task automatic pick_item(input int fill_pct, output vbra_pkg::opcode_t op,
                             output logic [15:0] sz);
        int r;
        r  = $urandom_range(0, 99);
        sz = 16'($urandom_range(0, 65535));
        if (r < 8)
            op = vbra_pkg::opcode_t'($urandom_range(0, 3));
        else if (wr_open)
        begin
            op = (r < 14) ? vbra_pkg::OP_RESERVE : vbra_pkg::OP_COMMIT;
            sz = pick_size();
        end
        else if (rd_open)
            op = (r < 14) ? vbra_pkg::OP_PEEK : vbra_pkg::OP_RELEASE;
        else if ($urandom_range(0, 99) < fill_pct)
        begin
            op = vbra_pkg::OP_RESERVE;
            sz = pick_size();
        end
        else
            op = vbra_pkg::OP_PEEK;
    endtask

    initial
    begin
        vbra_pkg::opcode_t op;
        logic [15:0]       sz;
        logic [15:0]       cap_value;
        int                fill_pct;

        steps = '{
            '{vbra_pkg::OP_PEEK,    16'd0,     1'b1, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_RELEASE, 16'd0,     1'b1, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_COMMIT,  16'd0,     1'b1, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_RESERVE, 16'd0,     1'b1, '{1'b1, 16'd0, 16'd0}},
            '{vbra_pkg::OP_RESERVE, 16'd5,     1'b1, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_COMMIT,  16'd0,     1'b1, '{1'b1, 16'd0, 16'd0}},
            '{vbra_pkg::OP_RESERVE, 16'hFFFF,  1'b1, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_RESERVE, 16'd4095,  1'b1, '{1'b1, 16'd0, 16'd0}},
            '{vbra_pkg::OP_COMMIT,  16'hFFFF,  1'b1, '{1'b1, 16'd0, 16'd0}},
            '{vbra_pkg::OP_PEEK,    16'd0,     1'b1, '{1'b1, 16'd0, 16'd0}},
            '{vbra_pkg::OP_PEEK,    16'd0,     1'b1, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_RELEASE, 16'd0,     1'b1, '{1'b1, 16'd0, 16'd0}},
            '{vbra_pkg::OP_PEEK,    16'd0,     1'b1, '{1'b1, 16'd0, 16'd4095}},
            '{vbra_pkg::OP_RELEASE, 16'hFFFF,  1'b1, '{1'b1, 16'd0, 16'd0}},
            // top full: wrap to zero, then fill the gap below the read start
            '{vbra_pkg::OP_RESERVE, 16'd100,   1'b0, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_COMMIT,  16'd0,     1'b0, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_RESERVE, 16'd3000,  1'b0, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_COMMIT,  16'd0,     1'b0, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_PEEK,    16'd0,     1'b0, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_RELEASE, 16'd0,     1'b0, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_PEEK,    16'd0,     1'b0, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_RELEASE, 16'd0,     1'b0, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_RESERVE, 16'hAAAA,  1'b0, '{1'b0, 16'd0, 16'd0}},
            '{vbra_pkg::OP_RELEASE, 16'h5555,  1'b0, '{1'b0, 16'd0, 16'd0}}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
            send(steps[i].op, steps[i].size, steps[i].pinned, steps[i].want);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0: cap_value = 16'd4096;
                1: cap_value = 16'd65535;
                // read start lands exactly on the buffer end, unless it is zero
                2: cap_value = (rd_start != 0) ? rd_start : 16'd200;
                3: cap_value = 16'd40;
                4: cap_value = 16'd1;
                5: cap_value = 16'($urandom_range(1, 65535));
                6: cap_value = 16'd65535;
                default: cap_value = 16'd300;
            endcase
            write_cap(cap_value);
            fill_pct = (ph % 3 == 0) ? 55 : ((ph % 3 == 1) ? 85 : 30);
            quiet    = (ph == 1) || (ph == 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick_item(fill_pct, op, sz);
                send(op, sz, 1'b0, '0);
                if ($urandom_range(0, 99) == 0)
                    settle();
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/vbra_pkg.sv
sv/vbra_size_queue.sv
sv/variable_block_ring_allocator.sv
tb/tb_variable_block_ring_allocator.sv
